[rtl/aarm_pkg.sv]
`timescale 1ns / 1ps
// aarm_pkg: types, constants and the q30 rounding helper of the rotation matrix block
// no dependencies; imported by aarm_sqrt, aarm_div, axis_angle_rotation_matrix_top and tb_top
package aarm_pkg;

  localparam int unsigned Q_FRAC = 30;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned QUO_W  = 31;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned POLY_N = 5;

  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  localparam logic [6:0] SIN_DIV [POLY_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [POLY_N] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  typedef struct packed {
    quad_e       quad;
    logic        swap;
    logic [13:0] rr;
  } ang_t;

  typedef struct packed {
    quad_e       quad;
    logic        swap;
    logic [29:0] theta;
    logic [29:0] x2;
  } sc_side_t;

  // round half away from zero, drop q30 fraction
  function automatic logic signed [65:0] rnd_q30(input logic signed [65:0] v);
    logic signed [65:0] h;
    h = v[65] ? 66'sd536870911 : 66'sd536870912;
    return (v + h) >>> Q_FRAC;
  endfunction

endpackage

[rtl/aarm_sqrt.sv]
`timescale 1ns / 1ps
// aarm_sqrt: pipelined integer square root, one result bit per stage
// depends on aarm_pkg
module aarm_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [aarm_pkg::RAD_W-1:0]    rad_i,
  output logic [aarm_pkg::LEN_W-1:0]    root_o
);
  import aarm_pkg::*;

  logic [RAD_W-1:0] rem_in [LEN_W];
  logic [RAD_W-1:0] res_in [LEN_W];
  logic [RAD_W-1:0] rem_d  [LEN_W];
  logic [RAD_W-1:0] res_d  [LEN_W];
  logic [RAD_W-1:0] rem_q  [LEN_W];
  logic [RAD_W-1:0] res_q  [LEN_W];

  for (genvar k = 0; k < LEN_W; k++) begin : g_link
    if (k == 0) begin : g_first
      assign rem_in[k] = rad_i;
      assign res_in[k] = '0;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign res_in[k] = res_q[k-1];
    end
  end

  always_comb begin
    logic [RAD_W-1:0] bitv;
    logic [RAD_W-1:0] trial;
    for (int k = 0; k < LEN_W; k++) begin
      bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      trial = res_in[k] + bitv;
      if (rem_in[k] >= trial) begin
        rem_d[k] = rem_in[k] - trial;
        res_d[k] = (res_in[k] >> 1) + bitv;
      end else begin
        rem_d[k] = rem_in[k];
        res_d[k] = res_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign root_o = res_q[LEN_W-1][LEN_W-1:0];

endmodule

[rtl/aarm_div.sv]
`timescale 1ns / 1ps
// aarm_div: pipelined restoring divider, rounded (mag << 46) / len, one quotient bit per stage
// depends on aarm_pkg
module aarm_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [aarm_pkg::MAG_W-1:0]    mag_i,
  input  logic [aarm_pkg::LEN_W-1:0]    len_i,
  output logic [aarm_pkg::QUO_W-1:0]    quo_o
);
  import aarm_pkg::*;

  localparam int unsigned NUM_SH = Q_FRAC + MAG_W;
  localparam int unsigned REM_W  = MAG_W + NUM_SH + 1;

  logic [REM_W-1:0] rem_in [QUO_W];
  logic [REM_W-1:0] rem_d  [QUO_W];
  logic [REM_W-1:0] rem_q  [QUO_W];
  logic [LEN_W-1:0] len_in [QUO_W];
  logic [LEN_W-1:0] len_q  [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [QUO_W-1:0] quo_d  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_link
    if (j == 0) begin : g_first
      assign rem_in[j] = REM_W'({mag_i, {NUM_SH{1'b0}}}) + REM_W'(len_i >> 1);
      assign len_in[j] = len_i;
      assign quo_in[j] = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign len_in[j] = len_q[j-1];
      assign quo_in[j] = quo_q[j-1];
    end
  end

  always_comb begin
    logic [REM_W-1:0] trial;
    for (int j = 0; j < QUO_W; j++) begin
      trial    = REM_W'(len_in[j]) << (QUO_W - 1 - j);
      quo_d[j] = quo_in[j];
      if (rem_in[j] >= trial) begin
        rem_d[j]                = rem_in[j] - trial;
        quo_d[j][QUO_W - 1 - j] = 1'b1;
      end else begin
        rem_d[j] = rem_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      len_q <= len_in;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

[rtl/axis_angle_rotation_matrix_top.sv]
`timescale 1ns / 1ps
// axis-angle to 3x3 rotation matrix, rodrigues formula, signed q1.OUT_FRAC_BITS entries
// one transfer per cycle sustained while the skid entry is empty
// the depth is set by the 32-stage square root and the 31-stage divider of the normalizer
// output register plus skid entry keep input open while one result waits
// reset (rst_ni low, async) clears all valid bits; payload registers are not reset
// depends on aarm_pkg, aarm_sqrt, aarm_div
module axis_angle_rotation_matrix_top #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // axis_x, axis_y, axis_z, turn_angle
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic [0:0]    m_axis_tuser    // zero_axis
);
  import aarm_pkg::*;

  localparam int unsigned PIPE_N = 69;
  localparam int unsigned MAG_N  = 33;
  localparam int unsigned SGN_N  = 64;
  localparam int unsigned ANG_N  = 47;
  localparam int unsigned ZF_N   = 68;
  localparam int unsigned RSH    = Q_FRAC - OUT_FRAC_BITS;
  localparam logic signed [35:0] RHALF = (36'sd1 <<< RSH) >>> 1;
  localparam logic signed [35:0] LIM   = 36'sd1 <<< OUT_FRAC_BITS;
  localparam logic [15:0] ONE_OUT = LIM[15:0];

  function automatic logic [15:0] to_out(input logic signed [34:0] v);
    logic signed [35:0] r;
    r = (36'(v) + RHALF - ((v < 0 && RHALF != 0) ? 36'sd1 : 36'sd0)) >>> RSH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[15:0];
  endfunction

  logic adv;

  // input fields
  logic signed [15:0] ax_in [3];
  logic [15:0]        turn_in;
  assign ax_in[0] = s_axis_tdata[15:0];
  assign ax_in[1] = s_axis_tdata[31:16];
  assign ax_in[2] = s_axis_tdata[47:32];
  assign turn_in  = s_axis_tdata[63:48];

  // control pipeline
  logic [PIPE_N-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_N-2:0], s_axis_tvalid};
    end
  end

  // stage 1: squares, magnitudes, angle folding
  logic [31:0]        n2_d;
  logic [2:0][15:0]   mag_d;
  logic [2:0]         sgn_d;
  ang_t               ang_d;
  logic               zf_d;

  always_comb begin
    logic [13:0] rraw;
    n2_d = '0;
    for (int i = 0; i < 3; i++) begin
      n2_d     = n2_d + 32'(ax_in[i] * ax_in[i]);
      sgn_d[i] = ax_in[i][15];
      mag_d[i] = ax_in[i][15] ? 16'(-ax_in[i]) : 16'(ax_in[i]);
    end
    zf_d       = (ax_in[0] == 16'sd0) && (ax_in[1] == 16'sd0) && (ax_in[2] == 16'sd0);
    rraw       = turn_in[13:0];
    ang_d.quad = quad_e'(turn_in[15:14]);
    ang_d.swap = rraw > 14'd8192;
    ang_d.rr   = ang_d.swap ? 14'(15'd16384 - 15'(rraw)) : rraw;
  end

  logic [31:0]      n2_q;
  logic [2:0][15:0] mag_q [MAG_N];
  logic [2:0]       sgn_q [SGN_N];
  ang_t             ang_q [ANG_N];
  logic             zf_q  [ZF_N];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n2_q     <= n2_d;
      mag_q[0] <= mag_d;
      sgn_q[0] <= sgn_d;
      ang_q[0] <= ang_d;
      zf_q[0]  <= zf_d;
      for (int i = 1; i < MAG_N; i++) mag_q[i] <= mag_q[i-1];
      for (int i = 1; i < SGN_N; i++) sgn_q[i] <= sgn_q[i-1];
      for (int i = 1; i < ANG_N; i++) ang_q[i] <= ang_q[i-1];
      for (int i = 1; i < ZF_N; i++)  zf_q[i]  <= zf_q[i-1];
    end
  end

  // normalizer: length then unit components
  logic [LEN_W-1:0] len;
  logic [QUO_W-1:0] quo [3];

  aarm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({n2_q, 32'd0}),
    .root_o (len)
  );

  for (genvar a = 0; a < 3; a++) begin : g_div
    aarm_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .mag_i (mag_q[MAG_N-1][a]),
      .len_i (len),
      .quo_o (quo[a])
    );
  end

  logic signed [31:0] u_q [3];
  always_ff @(posedge clk_i) begin
    logic [30:0] uc;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        uc = (quo[a] > ONE_Q30) ? ONE_Q30 : quo[a];
        u_q[a] <= sgn_q[SGN_N-1][a] ? -$signed({1'b0, uc}) : $signed({1'b0, uc});
      end
    end
  end

  // sine and cosine: angle scaling and square
  logic [45:0] thp_q;
  logic [29:0] theta_q, theta2_q;
  logic [59:0] thsq_q;
  sc_side_t    side48_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      thp_q    <= 46'(ang_q[43].rr) * 46'(TWO_PI_Q29);
      theta_q  <= 30'((thp_q + 46'd16384) >> 15);
      thsq_q   <= 60'(theta_q) * 60'(theta_q);
      theta2_q <= theta_q;
      side48_q <= '{quad:  ang_q[ANG_N-1].quad,
                    swap:  ang_q[ANG_N-1].swap,
                    theta: theta2_q,
                    x2:    30'((thsq_q + 60'd536870912) >> Q_FRAC)};
    end
  end

  // series evaluation, lane 0 sine, lane 1 cosine
  logic [30:0] h_s    [POLY_N+1][2];
  sc_side_t    side_s [POLY_N+1];

  assign side_s[0] = side48_q;
  assign h_s[0][0] = ONE_Q30;
  assign h_s[0][1] = ONE_Q30;

  for (genvar i = 0; i < POLY_N; i++) begin : g_poly
    sc_side_t sa_q, sb_q, sc_q;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sa_q <= side_s[i];
        sb_q <= sa_q;
        sc_q <= sb_q;
      end
    end
    assign side_s[i+1] = sc_q;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam logic [6:0]  K   = (l == 0) ? SIN_DIV[i] : COS_DIV[i];
      localparam logic [31:0] RCP = 32'((64'd1 << 32) / 64'(K));

      logic [60:0] prod_q;
      logic [31:0] v_q;
      logic [63:0] mr_q;
      logic [30:0] h_q;
      logic [30:0] p;
      logic [31:0] vn, q0, rem, qt;

      always_comb begin
        p   = 31'((prod_q + 61'd536870912) >> Q_FRAC);
        vn  = 32'(p) + 32'(K >> 1);
        q0  = mr_q[63:32];
        rem = v_q - 32'(q0 * 32'(K));
        qt  = (rem >= 32'(K)) ? q0 + 32'd1 : q0;
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          prod_q <= 61'(h_s[i][l]) * 61'(side_s[i].x2);
          v_q    <= vn;
          mr_q   <= 64'(vn) * 64'(RCP);
          h_q    <= ONE_Q30 - 31'(qt);
        end
      end
      assign h_s[i+1][l] = h_q;
    end
  end

  // final sine product, octant swap and quadrant
  logic [60:0]        fraw_q;
  logic [30:0]        hc_q;
  sc_side_t           sf_q;
  logic signed [31:0] s_q, c_q;
  logic signed [32:0] t_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fraw_q <= 61'(side_s[POLY_N].theta) * 61'(h_s[POLY_N][0]);
      hc_q   <= h_s[POLY_N][1];
      sf_q   <= side_s[POLY_N];
    end
  end

  logic [30:0]        sb, s0, c0;
  logic signed [31:0] s_d, c_d;
  always_comb begin
    sb = 31'((fraw_q + 61'd536870912) >> Q_FRAC);
    s0 = sf_q.swap ? hc_q : sb;
    c0 = sf_q.swap ? sb : hc_q;
    unique case (sf_q.quad)
      QUAD_0: begin
        s_d = $signed({1'b0, s0});
        c_d = $signed({1'b0, c0});
      end
      QUAD_1: begin
        s_d = $signed({1'b0, c0});
        c_d = -$signed({1'b0, s0});
      end
      QUAD_2: begin
        s_d = -$signed({1'b0, s0});
        c_d = -$signed({1'b0, c0});
      end
      QUAD_3: begin
        s_d = -$signed({1'b0, c0});
        c_d = $signed({1'b0, s0});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= s_d;
      c_q <= c_d;
      t_q <= $signed({2'b00, ONE_Q30}) - 33'(c_d);
    end
  end

  // matrix: products, products with t, sums, output rounding
  logic signed [63:0] pr_q [9];
  logic signed [31:0] c_m1_q, c_m2_q;
  logic signed [32:0] t_m1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= u_q[0] * u_q[0];
      pr_q[1] <= u_q[1] * u_q[1];
      pr_q[2] <= u_q[2] * u_q[2];
      pr_q[3] <= u_q[0] * u_q[1];
      pr_q[4] <= u_q[0] * u_q[2];
      pr_q[5] <= u_q[1] * u_q[2];
      pr_q[6] <= u_q[2] * s_q;
      pr_q[7] <= u_q[1] * s_q;
      pr_q[8] <= u_q[0] * s_q;
      c_m1_q  <= c_q;
      t_m1_q  <= t_q;
    end
  end

  logic signed [31:0] rd [9];
  always_comb begin
    for (int k = 0; k < 9; k++) rd[k] = 32'(rnd_q30(66'(pr_q[k])));
  end

  logic signed [65:0] tp_q [6];
  logic signed [31:0] sp_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) tp_q[k] <= rd[k] * t_m1_q;
      for (int k = 0; k < 3; k++) sp_q[k] <= rd[k+6];
      c_m2_q <= c_m1_q;
    end
  end

  logic signed [33:0] ta [6];
  logic signed [34:0] m_d [9];
  always_comb begin
    for (int k = 0; k < 6; k++) ta[k] = 34'(rnd_q30(tp_q[k]));
    m_d[0] = 35'(c_m2_q) + 35'(ta[0]);
    m_d[4] = 35'(c_m2_q) + 35'(ta[1]);
    m_d[8] = 35'(c_m2_q) + 35'(ta[2]);
    m_d[1] = 35'(ta[3]) - 35'(sp_q[0]);
    m_d[3] = 35'(ta[3]) + 35'(sp_q[0]);
    m_d[2] = 35'(ta[4]) + 35'(sp_q[1]);
    m_d[6] = 35'(ta[4]) - 35'(sp_q[1]);
    m_d[5] = 35'(ta[5]) - 35'(sp_q[2]);
    m_d[7] = 35'(ta[5]) + 35'(sp_q[2]);
  end

  logic signed [34:0] m_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) m_q <= m_d;
  end

  logic [143:0] mat_d, mat_q;
  logic         zo_q;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (zf_q[ZF_N-1]) begin
        mat_d[k*16 +: 16] = (k % 4 == 0) ? ONE_OUT : 16'd0;
      end else begin
        mat_d[k*16 +: 16] = to_out(m_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mat_q <= mat_d;
      zo_q  <= zf_q[ZF_N-1];
    end
  end

  // output register and skid entry
  logic         out_v_q, skid_v_q;
  logic [143:0] out_data_q, skid_data_q;
  logic         out_zero_q, skid_zero_q;
  logic         vld_last;

  assign vld_last = vld_q[PIPE_N-1];
  assign adv      = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (adv) begin
      if (out_v_q && !m_axis_tready) begin
        skid_v_q <= vld_last;
      end else begin
        out_v_q <= vld_last;
      end
    end else if (m_axis_tready) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (out_v_q && !m_axis_tready) begin
        skid_data_q <= mat_q;
        skid_zero_q <= zo_q;
      end else begin
        out_data_q <= mat_q;
        out_zero_q <= zo_q;
      end
    end else if (m_axis_tready) begin
      out_data_q <= skid_data_q;
      out_zero_q <= skid_zero_q;
    end
  end

  assign s_axis_tready   = adv;
  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_zero_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for axis_angle_rotation_matrix_top, with a fixed-point
// rodrigues predictor in a small scoreboard class; depends on aarm_pkg and the rtl
module tb_top;
  import aarm_pkg::*;

  localparam int unsigned FRAC = 14;
  localparam longint LIMIT = 400000;
  localparam longint unsigned ONE = 64'd1 << 30;
  localparam longint unsigned TWO_PI = 64'd3373259426;

  typedef struct {
    logic [143:0] mat;
    logic         zero;
  } rot_t;

  class rot_board;
    rot_t   want_q[$];
    int     errors;
    int     seen;

    function automatic longint unsigned mulq(longint unsigned a, longint unsigned b);
      return (a * b + (ONE >> 1)) >> 30;
    endfunction

    function automatic longint rshift(longint v, int n);
      longint unsigned h;
      h = 64'd1 << (n - 1);
      if (v >= 0) return longint'((unsigned'(v) + h) >> n);
      return -longint'((unsigned'(-v) + h) >> n);
    endfunction

    function automatic longint unsigned series(longint unsigned x2, bit is_sin);
      longint unsigned h, p, k;
      h = ONE;
      for (int i = 0; i < 5; i++) begin
        k = is_sin ? SIN_DIV[i] : COS_DIV[i];
        p = mulq(x2, h);
        h = ONE - (p + k / 2) / k;
      end
      return h;
    endfunction

    function automatic longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function automatic longint unit(longint a, longint unsigned len);
      longint unsigned m, u;
      m = (a < 0) ? unsigned'(-a) : unsigned'(a);
      u = ((m << 46) + len / 2) / len;
      if (u > ONE) u = ONE;
      return (a < 0) ? -longint'(u) : longint'(u);
    endfunction

    function automatic logic [15:0] entry(longint v);
      longint r;
      r = rshift(v, 30 - FRAC);
      if (r > (64'sd1 <<< FRAC)) r = 64'sd1 <<< FRAC;
      if (r < -(64'sd1 <<< FRAC)) r = -(64'sd1 <<< FRAC);
      return r[15:0];
    endfunction

    function void note_request(logic [63:0] d);
      rot_t w;
      longint ax, ay, az, ux, uy, uz, s, c, t, xx, yy, zz, xy, xz, yz;
      longint m[9];
      longint unsigned n2, len, r, theta, x2, sb, cb, s0, c0;
      quad_e quad;
      bit swap;
      ax = longint'($signed(d[15:0]));
      ay = longint'($signed(d[31:16]));
      az = longint'($signed(d[47:32]));
      w.zero = (ax == 0 && ay == 0 && az == 0);
      w.mat = '0;
      if (w.zero) begin
        w.mat[15:0] = 16'(1 << FRAC);
        w.mat[79:64] = 16'(1 << FRAC);
        w.mat[143:128] = 16'(1 << FRAC);
      end else begin
        n2 = unsigned'(ax * ax + ay * ay + az * az);
        len = root(n2 << 32);
        ux = unit(ax, len);
        uy = unit(ay, len);
        uz = unit(az, len);
        quad = quad_e'(d[63:62]);
        r = d[61:48];
        swap = r > 8192;
        if (swap) r = 16384 - r;
        theta = (r * TWO_PI + (64'd1 << 14)) >> 15;
        x2 = mulq(theta, theta);
        sb = mulq(theta, series(x2, 1'b1));
        cb = series(x2, 1'b0);
        s0 = swap ? cb : sb;
        c0 = swap ? sb : cb;
        case (quad)
          QUAD_0: begin s = s0; c = c0; end
          QUAD_1: begin s = c0; c = -longint'(s0); end
          QUAD_2: begin s = -longint'(s0); c = -longint'(c0); end
          default: begin s = -longint'(c0); c = s0; end
        endcase
        t = longint'(ONE) - c;
        xx = rshift(ux * ux, 30);
        yy = rshift(uy * uy, 30);
        zz = rshift(uz * uz, 30);
        xy = rshift(rshift(ux * uy, 30) * t, 30);
        xz = rshift(rshift(ux * uz, 30) * t, 30);
        yz = rshift(rshift(uy * uz, 30) * t, 30);
        m[0] = c + rshift(xx * t, 30);
        m[1] = xy - rshift(uz * s, 30);
        m[2] = xz + rshift(uy * s, 30);
        m[3] = xy + rshift(uz * s, 30);
        m[4] = c + rshift(yy * t, 30);
        m[5] = yz - rshift(ux * s, 30);
        m[6] = xz - rshift(uy * s, 30);
        m[7] = yz + rshift(ux * s, 30);
        m[8] = c + rshift(zz * t, 30);
        for (int i = 0; i < 9; i++) w.mat[16*i +: 16] = entry(m[i]);
      end
      want_q.push_back(w);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(logic [143:0] mat, logic zero);
      rot_t w;
      seen++;
      if (want_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      w = want_q.pop_front();
      for (int i = 0; i < 9; i++)
        if (mat[16*i +: 16] !== w.mat[16*i +: 16])
          report($sformatf("result %0d r%0d%0d got %h want %h", seen, i / 3, i % 3,
                           mat[16*i +: 16], w.mat[16*i +: 16]));
      if (zero !== w.zero)
        report($sformatf("result %0d zero_axis got %b want %b", seen, zero, w.zero));
    endtask
  endclass

  logic         clk, rst_n;
  logic         s_valid, s_ready, m_valid, m_ready;
  logic [63:0]  s_data;
  logic [143:0] m_data;
  logic [0:0]   m_user;

  rot_board board = new();
  int     send_idle, recv_stall;
  bit     hold_go, hold;
  longint cycles;
  int     sent;

  axis_angle_rotation_matrix_top #(.OUT_FRAC_BITS(FRAC)) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && m_valid && m_ready) board.check_result(m_data, m_user[0]);

  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk);
      m_ready <= !hold && ($urandom_range(99) >= recv_stall);
    end
  end

  // long receiver hold-off so the pipe fills and back-pressures the input
  initial begin
    hold = 1'b0;
    wait (hold_go);
    @(negedge clk);
    hold = 1'b1;
    repeat (400) @(negedge clk);
    hold = 1'b0;
  end

  task send(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] ang);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {ang, z, y, x};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    board.note_request(s_data);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(4))
      0: return {2'($urandom_range(3)), 14'd8192 + 14'($urandom_range(2)) - 14'd1};
      1: return {2'($urandom_range(3)), 14'($urandom_range(3))};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ext [4];
    logic [15:0] ang [10];
    int n;
    ext = '{16'h8000, 16'h7fff, 16'h0001, 16'hffff};
    ang = '{16'd0, 16'd1, 16'd8192, 16'd8193, 16'd16383,
            16'd16384, 16'd32768, 16'd49152, 16'd57000, 16'hffff};
    sent = 0;
    hold_go = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    s_valid = 1'b0;
    s_data = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero axis, extreme components, octant edges and quadrant turns
    send(16'h0000, 16'h0000, 16'h0000, 16'd12345);
    send(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 10; i++) send(16'h0000, 16'h0000, 16'h7fff, ang[i]);
    for (int i = 0; i < 4; i++) send(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ang[i + 5]);
    send(16'h8000, 16'h8000, 16'h8000, 16'd10000);
    send(16'h7fff, 16'h7fff, 16'h7fff, 16'd40000);
    send(16'h0001, 16'h0000, 16'h0000, 16'd8192);
    send(16'h0000, 16'hffff, 16'h0000, 16'd24576);

    n = 1550;
    for (int i = 0; i < n; i++) begin
      if (i < n / 3) begin
        send_idle = 34; recv_stall = 85;
      end else if (i < 2 * n / 3) begin
        send_idle = 85; recv_stall = 34;
      end else begin
        send_idle = 0; recv_stall = 0;
      end
      if (i == 1100) hold_go = 1'b1;
      if (i == 800) begin
        s_valid <= 1'b0;
        wait (board.want_q.size() == 0);
        @(negedge clk);
      end
      send(pick_comp(), pick_comp(), pick_comp(), pick_angle());
    end
    s_valid <= 1'b0;
    wait (board.want_q.size() == 0);
    repeat (100) @(posedge clk);

    $display("tb_top: %0d requests sent, %0d matrices checked, zero axis and", sent, board.seen);
    $display("tb_top: all quadrants covered under idling, stalls and a long hold-off");
    if (board.errors == 0 && board.want_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
